// ===== rtl/core/ulcp_pkg.sv =====
// Shared constants, result type and character-class helpers for the UART LED
// command parser. No dependencies.

package ulcp_pkg;

  // Line and pin limits
  localparam int unsigned LineMax  = 50;
  localparam int unsigned PinCount = 8;
  localparam int unsigned LedWidth = 8;
  localparam int unsigned PinLimit = (PinCount < LedWidth) ? PinCount : LedWidth;

  localparam logic [5:0] LenLimit = 6'(LineMax - 1);
  localparam logic [7:0] PinBound = 8'(PinLimit);
  localparam logic [5:0] CharMax  = 6'd63;
  localparam logic [2:0] TokMax   = 3'd7;

  // Token numbers as counted after the token has started
  localparam logic [2:0] TokKey    = 3'd2;
  localparam logic [2:0] TokAction = 3'd3;
  localparam logic [2:0] TokPin    = 3'd4;

  // Character codes
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharNul   = 8'd0;
  localparam logic [7:0] CharOpen  = 8'h5B;  // '['
  localparam logic [7:0] CharAt    = 8'h40;  // '@'
  localparam logic [7:0] CharClose = 8'h5D;  // ']'
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharVt    = 8'd11;
  localparam logic [7:0] CharFf    = 8'd12;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharL     = 8'h4C;
  localparam logic [7:0] CharE     = 8'h45;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharO     = 8'h4F;
  localparam logic [7:0] CharN     = 8'h4E;

  // Number parse phases
  localparam logic [1:0] NumSpace = 2'd0;
  localparam logic [1:0] NumSign  = 2'd1;
  localparam logic [1:0] NumDigit = 2'd2;
  localparam logic [1:0] NumDone  = 2'd3;

  typedef struct packed {
    logic [LedWidth-1:0] led_state;
    logic                command_ok;
    logic                line_overflow;
  } result_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CharOpen) || (c == CharAt) || (c == CharClose);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharLf) ||
           (c == CharVt) || (c == CharFf);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic [7:0] key_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CharL;
      2'd1:    ch = CharE;
      default: ch = CharD;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] on_char(input logic idx);
    return idx ? CharN : CharO;
  endfunction

endpackage

// ===== rtl/core/ulcp_parse.sv =====
// Per-line parse state: tokenizer, keyword match, pin number and LED register.
// Depends on ulcp_pkg.

module ulcp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output ulcp_pkg::result_t   result_o
);

  logic [2:0] tok_q, tok_d;
  logic [5:0] cit_q, cit_d;
  logic       inside_q, inside_d;
  logic       key_q, key_d;
  logic       act_q, act_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] phase_q, phase_d;
  logic       neg_q, neg_d;
  logic [5:0] len_q, len_d;
  logic       nul_q, nul_d;
  logic       drop_q, drop_d;
  logic [ulcp_pkg::LedWidth-1:0] led_q, led_d;

  logic        fin_key, fin_act;
  logic [2:0]  tok_n;
  logic [5:0]  cit_n;
  logic [11:0] prod;
  logic [7:0]  pin;
  logic        pin_ok, ok;
  logic [ulcp_pkg::LedWidth-1:0] led_new, pin_mask;

  // Effect of closing the current token
  assign fin_key = key_q & ~(inside_q && tok_q == ulcp_pkg::TokKey && cit_q != 6'd3);
  assign fin_act = act_q & ~(inside_q && tok_q == ulcp_pkg::TokAction && cit_q != 6'd2);

  assign tok_n = inside_q ? tok_q : ((tok_q == ulcp_pkg::TokMax) ? tok_q : tok_q + 3'd1);
  assign cit_n = inside_q ? cit_q : 6'd0;

  // acc * 10 + digit, saturated to 8 bits below
  assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {8'd0, byte_i[3:0]};

  // Line-end evaluation
  assign pin    = (tok_q >= ulcp_pkg::TokPin) ? acc_q : 8'd0;
  assign pin_ok = ~(neg_q && pin != 8'd0) && (pin < ulcp_pkg::PinBound);
  assign ok     = (tok_q >= ulcp_pkg::TokAction) && fin_key && pin_ok;

  always_comb begin
    pin_mask = '0;
    pin_mask[pin[$clog2(ulcp_pkg::LedWidth)-1:0]] = 1'b1;
    if (!ok) begin
      led_new = led_q;
    end else if (fin_act) begin
      led_new = led_q | pin_mask;
    end else begin
      led_new = led_q & ~pin_mask;
    end
  end

  assign result_o.led_state     = led_new;
  assign result_o.command_ok    = ok;
  assign result_o.line_overflow = drop_q;

  always_comb begin
    tok_d    = tok_q;
    cit_d    = cit_q;
    inside_d = inside_q;
    key_d    = key_q;
    act_d    = act_q;
    acc_d    = acc_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    len_d    = len_q;
    nul_d    = nul_q;
    drop_d   = drop_q;
    led_d    = led_q;
    if (step_i) begin
      if (byte_i == ulcp_pkg::CharCr) begin
        led_d    = led_new;
        tok_d    = 3'd0;
        cit_d    = 6'd0;
        inside_d = 1'b0;
        key_d    = 1'b1;
        act_d    = 1'b1;
        acc_d    = 8'd0;
        phase_d  = ulcp_pkg::NumSpace;
        neg_d    = 1'b0;
        len_d    = 6'd0;
        nul_d    = 1'b0;
        drop_d   = 1'b0;
      end else if (nul_q || len_q >= ulcp_pkg::LenLimit) begin
        drop_d = 1'b1;
      end else begin
        len_d = len_q + 6'd1;
        if (byte_i == ulcp_pkg::CharNul) begin
          nul_d = 1'b1;
        end else if (ulcp_pkg::is_delim(byte_i)) begin
          key_d    = fin_key;
          act_d    = fin_act;
          inside_d = 1'b0;
        end else begin
          tok_d    = tok_n;
          inside_d = 1'b1;
          cit_d    = (cit_n == ulcp_pkg::CharMax) ? cit_n : cit_n + 6'd1;
          if (tok_n == ulcp_pkg::TokKey) begin
            if (cit_n >= 6'd3 || ulcp_pkg::key_char(cit_n[1:0]) != byte_i) begin
              key_d = 1'b0;
            end
          end else if (tok_n == ulcp_pkg::TokAction) begin
            if (cit_n >= 6'd2 || ulcp_pkg::on_char(cit_n[0]) != byte_i) begin
              act_d = 1'b0;
            end
          end else if (tok_n == ulcp_pkg::TokPin) begin
            if (phase_q == ulcp_pkg::NumSpace && ulcp_pkg::is_space(byte_i)) begin
              // skip leading white space
            end else if (phase_q == ulcp_pkg::NumSpace &&
                         (byte_i == ulcp_pkg::CharPlus || byte_i == ulcp_pkg::CharMinus)) begin
              neg_d   = (byte_i == ulcp_pkg::CharMinus);
              phase_d = ulcp_pkg::NumSign;
            end else if (phase_q == ulcp_pkg::NumDone) begin
              // number finished, ignore the rest
            end else if (!ulcp_pkg::is_digit(byte_i)) begin
              phase_d = ulcp_pkg::NumDone;
            end else begin
              acc_d   = (prod > 12'd255) ? 8'd255 : prod[7:0];
              phase_d = ulcp_pkg::NumDigit;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 3'd0;
      cit_q    <= 6'd0;
      inside_q <= 1'b0;
      key_q    <= 1'b1;
      act_q    <= 1'b1;
      acc_q    <= 8'd0;
      phase_q  <= ulcp_pkg::NumSpace;
      neg_q    <= 1'b0;
      len_q    <= 6'd0;
      nul_q    <= 1'b0;
      drop_q   <= 1'b0;
      led_q    <= '0;
    end else begin
      tok_q    <= tok_d;
      cit_q    <= cit_d;
      inside_q <= inside_d;
      key_q    <= key_d;
      act_q    <= act_d;
      acc_q    <= acc_d;
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      len_q    <= len_d;
      nul_q    <= nul_d;
      drop_q   <= drop_d;
      led_q    <= led_d;
    end
  end

endmodule

// ===== rtl/core/uart_led_command_parser.sv =====
// UART LED command parser: one received byte per beat, one result beat per line.
// Each byte is captured in the input register and parsed from there; the result
// for a carriage return is then loaded into the result register.
// Throughput: one byte per cycle; a carriage return waits only while the result
// register holds an untaken beat. Reset clears the LEDs and all line state.
// Depends on ulcp_pkg and ulcp_parse.

module uart_led_command_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] led_state_o,
  output logic       command_ok_o,
  output logic       line_overflow_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Result register
  logic              out_valid_q;
  ulcp_pkg::result_t out_q;
  ulcp_pkg::result_t result;

  logic out_free;  // result register can take a beat at this edge
  logic is_cr;
  logic step;      // parse the held byte at this edge

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign is_cr    = (in_byte_q == ulcp_pkg::CharCr);
  // Plain bytes never produce a beat, so only a carriage return waits on the output.
  assign step     = in_valid_q & (~is_cr | out_free);

  // Hold the input register while its byte cannot advance.
  assign in_stall_o = in_valid_q & ~step;

  ulcp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Load a line result on carriage return; drop the valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step & is_cr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_free && step && is_cr) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_state_o     = out_q.led_state;
  assign command_ok_o    = out_q.command_ok;
  assign line_overflow_o = out_q.line_overflow;

endmodule

// ===== rtl/core/ulcp_checker.sv =====
// Port-level checks for uart_led_command_parser, attached by bind.
// Depends on the top level's ports only.

module ulcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] led_state_o,
  input logic       command_ok_o,
  input logic       line_overflow_o
);

  // LED state shown by the last delivered beat
  logic [7:0] last_led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_led_q <= 8'd0;
    end else if (out_valid_o && !out_stall_i) begin
      last_led_q <= led_state_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(led_state_o) && $stable(command_ok_o) && $stable(line_overflow_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !command_ok_o |-> led_state_o == last_led_q)
    else $error("LEDs changed on a line that was no command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_ok_o |-> $countones(led_state_o ^ last_led_q) <= 1)
    else $error("command changed more than one LED");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && $past(!out_valid_o) |-> $stable(led_state_o))
    else $error("LED output moved without a result beat");

endmodule

bind uart_led_command_parser ulcp_checker u_ulcp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .led_state_o     (led_state_o),
  .command_ok_o    (command_ok_o),
  .line_overflow_o (line_overflow_o)
);
